// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pds_pkg.sv =====
package pds_pkg;

  localparam int unsigned MAX_PAIRS_DEF  = 65536;
  localparam int unsigned COORD_BITS_DEF = 20;
  localparam int unsigned PAIR_CAP       = 131071;

  localparam int unsigned SUM_W   = 60;
  localparam int unsigned HIT_W   = 19;
  localparam int unsigned PAIR_W  = 17;
  localparam int unsigned RMSD_W  = 21;

  localparam logic [1:0] MODE_HA     = 2'd0;
  localparam logic [1:0] MODE_TS     = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_THR  = 2'd1;
  localparam logic [1:0] REG_NORM = 2'd2;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [HIT_W-1:0]  HIT_MAX  = {HIT_W{1'b1}};
  localparam logic [RMSD_W-1:0] RMSD_MAX = {RMSD_W{1'b1}};

  // One finished set, queued between front and back.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [HIT_W-1:0]  hits;
    logic [PAIR_W-1:0] pairs;
    logic              ovf;
    logic              single;
    logic              norm;
  } set_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum_sq_dist;
    logic [HIT_W-1:0]  within_count;
    logic [PAIR_W-1:0] pair_count;
    logic [HIT_W-1:0]  score;
    logic [RMSD_W-1:0] rmsd;
    logic              overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SQRT, ST_NDIV, ST_OUT
  } back_st_t;

endpackage

// ===== hw/rtl/pds_if.sv =====
interface pds_in_if #(parameter int unsigned CoordBits = pds_pkg::COORD_BITS_DEF) ();
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] ref_x;
  logic signed [CoordBits-1:0] ref_y;
  logic signed [CoordBits-1:0] ref_z;
  logic signed [CoordBits-1:0] mod_x;
  logic signed [CoordBits-1:0] mod_y;
  logic signed [CoordBits-1:0] mod_z;
  logic                        last_pair;
  modport source (output valid, ref_x, ref_y, ref_z, mod_x, mod_y, mod_z, last_pair,
                  input ready);
  modport sink (input valid, ref_x, ref_y, ref_z, mod_x, mod_y, mod_z, last_pair,
                output ready);
endinterface

interface pds_out_if ();
  logic                          valid;
  logic                          ready;
  logic [pds_pkg::SUM_W-1:0]     sum_sq_dist;
  logic [pds_pkg::HIT_W-1:0]     within_count;
  logic [pds_pkg::PAIR_W-1:0]    pair_count;
  logic [pds_pkg::HIT_W-1:0]     score;
  logic [pds_pkg::RMSD_W-1:0]    rmsd;
  logic                          overflow;
  modport source (output valid, sum_sq_dist, within_count, pair_count, score, rmsd,
                  overflow, input ready);
  modport sink (input valid, sum_sq_dist, within_count, pair_count, score, rmsd,
                overflow, output ready);
endinterface

interface pds_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/paired_deviation_scorer.sv =====
// paired_deviation_scorer: per-pair squared distance, GDT hits, RMSD per set.
// Throughput: one pair per cycle while input is not stalled; the back takes a
//   new set only once the result of the last one is taken. Input stalls once
//   two sets wait.
// Reset: synchronous active-low rst_n clears accumulators, queue and back FSM;
//   registers return to score_mode 1, gdt_threshold 256, normalize 0.
`include "assert_macros.svh"
module paired_deviation_scorer #(
  parameter int unsigned MAX_PAIRS  = pds_pkg::MAX_PAIRS_DEF,
  parameter int unsigned COORD_BITS = pds_pkg::COORD_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  pds_in_if.sink    in_ch,
  pds_out_if.source out_ch,
  pds_cfg_if.sink   cfg_ch
);
  localparam int unsigned QDEPTH = 4;

  logic [1:0]  score_mode_r;
  logic [15:0] gdt_threshold_r;
  logic        normalize_r;

  // Config registers; always ready, block is idle by contract.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_mode_r    <= pds_pkg::MODE_TS;
      gdt_threshold_r <= 16'd256;
      normalize_r     <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pds_pkg::REG_MODE: score_mode_r    <= cfg_ch.data[1:0];
        pds_pkg::REG_THR:  gdt_threshold_r <= cfg_ch.data;
        pds_pkg::REG_NORM: normalize_r     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  logic          in_fire, front_busy, set_valid, q_valid, q_full, set_take;
  pds_pkg::set_t set_data, q_data;
  pds_pkg::result_t res;

  // Hold off input while the queue may not absorb in-flight sets.
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  pds_front #(.MAX_PAIRS(MAX_PAIRS), .COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_fire,
    .ref_x(in_ch.ref_x), .ref_y(in_ch.ref_y), .ref_z(in_ch.ref_z),
    .mod_x(in_ch.mod_x), .mod_y(in_ch.mod_y), .mod_z(in_ch.mod_z),
    .last_pair(in_ch.last_pair),
    .score_mode(score_mode_r), .gdt_threshold(gdt_threshold_r),
    .normalize(normalize_r),
    .busy(front_busy), .set_valid, .set_data
  );

  // Depth 4: after the last accepted beat up to two sets still land
  // (stage 2, stage 1), so input stops at two queued.
  pds_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst_n, .wr_en(set_valid), .wr_data(set_data),
    .rd_en(set_take), .rd_valid(q_valid), .rd_data(q_data),
    .almost_full(q_full)
  );

  pds_back u_back (
    .clk, .rst_n, .set_valid(q_valid), .set_data(q_data), .set_take,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.sum_sq_dist  = res.sum_sq_dist;
  assign out_ch.within_count = res.within_count;
  assign out_ch.pair_count   = res.pair_count;
  assign out_ch.score        = res.score;
  assign out_ch.rmsd         = res.rmsd;
  assign out_ch.overflow     = res.overflow;

  `ASSERT_IMP(a_take_needs_data, set_take, q_valid, "set taken from empty queue")
  `ASSERT_IMP(a_result_nonempty, out_ch.valid, out_ch.pair_count != '0, "empty set result")
  `ASSERT_IMP(a_no_overrun, set_valid && !set_take, int'(u_fifo.cnt_r) < QDEPTH, "queue overrun")
  `ASSERT_NEXT(a_front_idle, !in_fire, !front_busy, "front busy without a beat")
endmodule

// ===== hw/rtl/pds_front.sv =====
// Per-pair squared distance, threshold hits and accumulation.
// Stage 1 registers squared deltas, stage 2 sums, compares, accumulates.
module pds_front #(
  parameter int unsigned MAX_PAIRS  = pds_pkg::MAX_PAIRS_DEF,
  parameter int unsigned COORD_BITS = pds_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic signed [COORD_BITS-1:0] ref_z,
  input  logic signed [COORD_BITS-1:0] mod_x,
  input  logic signed [COORD_BITS-1:0] mod_y,
  input  logic signed [COORD_BITS-1:0] mod_z,
  input  logic                         last_pair,
  input  logic [1:0]                   score_mode,
  input  logic [15:0]                  gdt_threshold,
  input  logic                         normalize,
  output logic                         busy,
  output logic                         set_valid,
  output pds_pkg::set_t                set_data
);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned LIM_I = (MAX_PAIRS > pds_pkg::PAIR_CAP) ?
                                  pds_pkg::PAIR_CAP : MAX_PAIRS;
  localparam logic [pds_pkg::PAIR_W-1:0] LIMIT = LIM_I[pds_pkg::PAIR_W-1:0];

  logic signed [DW-1:0] dx, dy, dz;
  logic [SW-1:0] sx_r, sy_r, sz_r;
  logic          v1_r, last1_r;
  logic [31:0]   thr_sq_r;
  logic [pds_pkg::SUM_W-1:0]  sum_r;
  logic [pds_pkg::HIT_W-1:0]  hit_r;
  logic [pds_pkg::PAIR_W-1:0] pairs_r;
  logic                       ovf_r;
  logic [pds_pkg::SUM_W-1:0]  d2;
  logic [2:0]                 hits;
  logic [pds_pkg::SUM_W:0]    sum_add;
  logic [pds_pkg::HIT_W:0]    hit_add;
  logic                       full;
  logic [pds_pkg::SUM_W-1:0]  sum_nxt;
  logic [pds_pkg::HIT_W-1:0]  hit_nxt;
  logic [pds_pkg::PAIR_W-1:0] pairs_nxt;
  logic                       ovf_nxt;

  assign dx = DW'(ref_x) - DW'(mod_x);
  assign dy = DW'(ref_y) - DW'(mod_y);
  assign dz = DW'(ref_z) - DW'(mod_z);

  always_ff @(posedge clk) begin
    sx_r     <= SW'(dx) * SW'(dx);
    sy_r     <= SW'(dy) * SW'(dy);
    sz_r     <= SW'(dz) * SW'(dz);
    last1_r  <= last_pair;
    thr_sq_r <= 32'(gdt_threshold) * 32'(gdt_threshold);
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_fire;
  end

  assign d2 = pds_pkg::SUM_W'(sx_r) + pds_pkg::SUM_W'(sy_r) + pds_pkg::SUM_W'(sz_r);

  // Mode must stay stable while a pair is in flight (config only when idle); the block itself does not enforce it.
  always_comb begin
    hits = 3'd0;
    if (score_mode[1]) begin
      hits = (d2 < pds_pkg::SUM_W'(thr_sq_r)) ? 3'd1 : 3'd0;
    end else if (score_mode == pds_pkg::MODE_HA) begin
      hits = 3'(d2 < 60'd16384) + 3'(d2 < 60'd65536) + 3'(d2 < 60'd262144)
           + 3'(d2 < 60'd1048576);
    end else begin
      hits = 3'(d2 < 60'd65536) + 3'(d2 < 60'd262144) + 3'(d2 < 60'd1048576)
           + 3'(d2 < 60'd4194304);
    end
  end

  assign full    = pairs_r >= LIMIT;
  assign sum_add = {1'b0, sum_r} + {1'b0, d2};
  assign hit_add = {1'b0, hit_r} + (pds_pkg::HIT_W + 1)'(hits);

  always_comb begin
    sum_nxt   = sum_r;
    hit_nxt   = hit_r;
    pairs_nxt = pairs_r;
    ovf_nxt   = ovf_r;
    if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      sum_nxt   = sum_add[pds_pkg::SUM_W] ? pds_pkg::SUM_MAX : sum_add[pds_pkg::SUM_W-1:0];
      hit_nxt   = hit_add[pds_pkg::HIT_W] ? pds_pkg::HIT_MAX : hit_add[pds_pkg::HIT_W-1:0];
      pairs_nxt = pairs_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      hit_r     <= '0;
      pairs_r   <= '0;
      ovf_r     <= 1'b0;
      set_valid <= 1'b0;
    end else begin
      set_valid <= v1_r && last1_r;
      if (v1_r) begin
        if (last1_r) begin
          sum_r   <= '0;
          hit_r   <= '0;
          pairs_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          sum_r   <= sum_nxt;
          hit_r   <= hit_nxt;
          pairs_r <= pairs_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && last1_r) begin
      set_data.sum    <= sum_nxt;
      set_data.hits   <= hit_nxt;
      set_data.pairs  <= pairs_nxt;
      set_data.ovf    <= ovf_nxt;
      set_data.single <= score_mode[1];
      set_data.norm   <= normalize;
    end
  end

  assign busy = v1_r;
endmodule

// ===== hw/rtl/pds_fifo.sv =====
// Small set queue between front and back.
module pds_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  pds_pkg::set_t wr_data,
  input  logic          rd_en,
  output logic          rd_valid,
  output pds_pkg::set_t rd_data,
  output logic          almost_full
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pds_pkg::set_t    mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  // Leaves room for the two sets that can still land after input stops.
  assign rd_valid    = cnt_r != '0;
  assign rd_data     = mem[rp_r];
  assign almost_full = cnt_r >= (AW+1)'(DEPTH - 2);
endmodule

// ===== hw/rtl/pds_back.sv =====
// Per-set finish: restoring divide sum/n, bit-pair isqrt, optional
// normalizing divide, then an output register.
module pds_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          set_valid,
  input  pds_pkg::set_t set_data,
  output logic          set_take,
  output logic          res_valid,
  input  logic          res_ready,
  output pds_pkg::result_t res
);
  localparam int unsigned SW = pds_pkg::SUM_W;
  localparam int unsigned QW = 35; // hit<<16

  pds_pkg::back_st_t st_r, st_nxt;
  pds_pkg::set_t     set_r;
  logic [SW-1:0]     rem_r, quo_r, den_r;
  logic [SW-1:0]     root_r;
  logic [5:0]        cnt_r;
  logic [SW+1:0]     trial;
  logic [SW-1:0]     shrem;
  logic [SW+1:0]     srem;
  logic [SW+1:0]     strial;
  logic [QW-1:0]     nq;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pds_pkg::ST_IDLE: if (set_valid) st_nxt = pds_pkg::ST_DIV;
      pds_pkg::ST_DIV:  if (cnt_r == 6'd0) st_nxt = pds_pkg::ST_SQRT;
      pds_pkg::ST_SQRT: if (cnt_r == 6'd0)
                          st_nxt = set_r.norm ? pds_pkg::ST_NDIV : pds_pkg::ST_OUT;
      pds_pkg::ST_NDIV: if (cnt_r == 6'd0) st_nxt = pds_pkg::ST_OUT;
      pds_pkg::ST_OUT:  if (res_ready) st_nxt = pds_pkg::ST_IDLE;
      default:          st_nxt = pds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    set_take  = 1'b0;
    res_valid = 1'b0;
    unique case (st_r)
      pds_pkg::ST_IDLE: set_take  = set_valid;
      pds_pkg::ST_OUT:  res_valid = 1'b1;
      default: ;
    endcase
  end

  // step helpers; the divide step is shared by both divides
  assign shrem  = {rem_r[SW-2:0], quo_r[SW-1]};
  assign trial  = {2'b00, shrem} - {2'b00, den_r};
  // isqrt: rem holds remainder, quo holds remaining radicand bits
  assign srem   = {rem_r, quo_r[SW-1:SW-2]};
  assign strial = srem - {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= pds_pkg::ST_IDLE;
    else        st_r <= st_nxt;
    unique case (st_r)
      pds_pkg::ST_IDLE: begin
        set_r <= set_data;
        rem_r <= '0;
        quo_r <= set_data.sum;
        den_r <= SW'(set_data.pairs);
        cnt_r <= 6'(SW - 1);
      end
      pds_pkg::ST_DIV: begin
        if (!trial[SW+1]) begin
          rem_r <= trial[SW-1:0];
          quo_r <= {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= shrem;
          quo_r <= {quo_r[SW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd0) begin
          // root starts from a clean remainder
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= 6'(SW/2 - 1);
        end
      end
      pds_pkg::ST_SQRT: begin
        if (!strial[SW+1]) begin
          rem_r  <= strial[SW-1:0];
          root_r <= {root_r[SW-2:0], 1'b1};
        end else begin
          rem_r  <= srem[SW-1:0];
          root_r <= {root_r[SW-2:0], 1'b0};
        end
        quo_r <= {quo_r[SW-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd0) begin
          rem_r <= '0;
          quo_r <= SW'({set_r.hits, 16'd0}) << (SW - QW);
          den_r <= set_r.single ? SW'(set_r.pairs) : SW'({set_r.pairs, 2'b00});
          cnt_r <= 6'(QW - 1);
        end
      end
      pds_pkg::ST_NDIV: begin
        if (!trial[SW+1]) begin
          rem_r <= trial[SW-1:0];
          quo_r <= {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= shrem;
          quo_r <= {quo_r[SW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign nq = quo_r[QW-1:0];

  always_comb begin
    res.sum_sq_dist  = set_r.sum;
    res.within_count = set_r.hits;
    res.pair_count   = set_r.pairs;
    res.overflow     = set_r.ovf;
    res.rmsd         = (root_r > SW'(pds_pkg::RMSD_MAX)) ? pds_pkg::RMSD_MAX
                                                         : root_r[pds_pkg::RMSD_W-1:0];
    if (set_r.norm)
      res.score = (nq > QW'(pds_pkg::HIT_MAX)) ? pds_pkg::HIT_MAX : nq[pds_pkg::HIT_W-1:0];
    else
      res.score = set_r.hits;
  end
endmodule
